// ===== rtl/ataf_pkg.sv =====
// Shared types, codes and decode helpers for the ATA taskfile LBA48 capture block.
package ataf_pkg;

  localparam int NumDev = 2;
  localparam int NumReg = 7;
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  // Tags and register codes
  localparam logic [15:0] TAG_CMD_DEV0 = 16'h0274;
  localparam logic [15:0] TAG_CMD_DEV1 = 16'h0374;
  localparam logic [3:0]  GROUP_DEV0   = 4'h2;
  localparam logic [3:0]  GROUP_DEV1   = 4'h3;
  localparam logic [7:0]  CODE_FEAT    = 8'h58;
  localparam logic [7:0]  CODE_COUNT   = 8'h5c;
  localparam logic [7:0]  CODE_SECT    = 8'h60;
  localparam logic [7:0]  CODE_LCYL    = 8'h64;
  localparam logic [7:0]  CODE_HCYL    = 8'h68;
  localparam logic [7:0]  CODE_SEL     = 8'h6c;
  localparam logic [7:0]  CODE_CMD     = 8'h74;

  // ATA command and feature codes
  localparam logic [7:0] CMD_IDENTIFY_PKT  = 8'h8e;
  localparam logic [7:0] FEAT_IDENTIFY     = 8'hec;
  localparam logic [7:0] CMD_READ_DMA_EXT  = 8'h25;
  localparam logic [7:0] CMD_READ_DMA      = 8'hc8;
  localparam logic [7:0] CMD_WRITE_DMA_EXT = 8'h35;
  localparam logic [7:0] CMD_WRITE_DMA     = 8'hca;

  localparam logic [16:0] MAX_SECS_EXT = 17'h10000;
  localparam logic [16:0] MAX_SECS_STD = 17'h00100;

  typedef enum logic [2:0] {
    REG_FEAT, REG_COUNT, REG_SECT, REG_LCYL, REG_HCYL, REG_SEL, REG_CMD
  } reg_sel_t;

  typedef enum logic [1:0] {
    ROUTE_IDENTIFY = 2'd0,
    ROUTE_LBA48    = 2'd1,
    ROUTE_PLAIN    = 2'd2
  } route_t;

  typedef enum logic [1:0] {
    DIR_READ   = 2'd0,
    DIR_WRITE  = 2'd1,
    DIR_CALLER = 2'd2
  } dir_t;

  // Decoded entry travelling from front to back
  typedef struct packed {
    logic       last;
    logic       tag_ok;
    logic       dev;
    logic [1:0] dev_wr;
    logic       reg_hit;
    reg_sel_t   reg_sel;
    logic [7:0] value;
  } op_t;

  // One result item
  typedef struct packed {
    logic        status;
    logic        device_index;
    logic [7:0]  command_code;
    logic [47:0] taskfile_low;
    logic [39:0] taskfile_high;
    logic [1:0]  route_class;
    logic [1:0]  dma_direction;
    logic [16:0] transfer_sectors;
    logic [25:0] transfer_bytes;
  } res_t;

  function automatic logic is_lba48(input logic [7:0] cmd);
    logic hit;
    case (cmd)
      8'h24, 8'h25, 8'h26, 8'h27, 8'h29, 8'h2f,
      8'h34, 8'h35, 8'h36, 8'h37, 8'h39, 8'h3f,
      8'h42, 8'hea, 8'hef: hit = 1'b1;
      default:             hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

// ===== rtl/ataf_if.sv =====
// Valid/ready channel interfaces for taskfile entries and capture results.
interface ataf_entry_if;
  logic        valid;
  logic        ready;
  logic [15:0] entry_tag;
  logic [15:0] entry_value;
  logic        last_entry;

  modport source(output valid, entry_tag, entry_value, last_entry, input ready);
  modport sink(input valid, entry_tag, entry_value, last_entry, output ready);
endinterface

interface ataf_result_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic        device_index;
  logic [7:0]  command_code;
  logic [47:0] taskfile_low;
  logic [39:0] taskfile_high;
  logic [1:0]  route_class;
  logic [1:0]  dma_direction;
  logic [16:0] transfer_sectors;
  logic [25:0] transfer_bytes;

  modport source(output valid, status, device_index, command_code, taskfile_low,
                 taskfile_high, route_class, dma_direction, transfer_sectors,
                 transfer_bytes, input ready);
  modport sink(input valid, status, device_index, command_code, taskfile_low,
               taskfile_high, route_class, dma_direction, transfer_sectors,
               transfer_bytes, output ready);
endinterface

// ===== rtl/ataf_front.sv =====
// Front end: accept taskfile entries and decode them into register operations.
module ataf_front (
  ataf_entry_if.sink   entry,
  output logic         push_valid,
  input  logic         push_ready,
  output ataf_pkg::op_t push_op
);
  import ataf_pkg::*;

  logic [3:0] group;
  logic [7:0] code;

  assign group = entry.entry_tag[11:8];
  assign code  = entry.entry_tag[7:0];

  // Pass the handshake through to the queue
  assign push_valid  = entry.valid;
  assign entry.ready = push_ready;

  // Decode register code, target devices and final tag
  always_comb begin
    push_op.reg_hit = 1'b1;
    case (code)
      CODE_FEAT:  push_op.reg_sel = REG_FEAT;
      CODE_COUNT: push_op.reg_sel = REG_COUNT;
      CODE_SECT:  push_op.reg_sel = REG_SECT;
      CODE_LCYL:  push_op.reg_sel = REG_LCYL;
      CODE_HCYL:  push_op.reg_sel = REG_HCYL;
      CODE_SEL:   push_op.reg_sel = REG_SEL;
      CODE_CMD:   push_op.reg_sel = REG_CMD;
      default: begin
        push_op.reg_sel = REG_FEAT;
        push_op.reg_hit = 1'b0;
      end
    endcase
    push_op.dev_wr[0] = (group != GROUP_DEV1);
    push_op.dev_wr[1] = (group != GROUP_DEV0);
    push_op.value     = entry.entry_value[7:0];
    push_op.last      = entry.last_entry;
    push_op.tag_ok    = (entry.entry_tag == TAG_CMD_DEV0) ||
                        (entry.entry_tag == TAG_CMD_DEV1);
    push_op.dev       = (entry.entry_tag == TAG_CMD_DEV1);
  end

endmodule

// ===== rtl/ataf_queue.sv =====
// Short FIFO of decoded operations between the front and back ends.
module ataf_queue #(
  parameter int DEPTH = ataf_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  ataf_pkg::op_t push_op,
  output logic          pop_valid,
  input  logic          pop_ready,
  output ataf_pkg::op_t pop_op
);
  import ataf_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  op_t            mem [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            push;
  logic            pop;

  assign push_ready = (count != CntW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_op     = mem[rd_ptr];

  // Store incoming operation
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_op;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/ataf_back.sv =====
// Back end: apply register writes to the shadow stores and build the result item.
module ataf_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  ataf_pkg::op_t  pop_op,
  ataf_result_if.source  result
);
  import ataf_pkg::*;

  logic [7:0] cur  [NumDev][NumReg];
  logic [7:0] high [NumDev][NumReg];
  logic       hit  [NumDev][NumReg];
  logic [7:0] c_view [NumReg];
  logic [7:0] h_view [NumReg];
  logic       pop;
  logic       res_valid;
  res_t       res;
  res_t       res_next;
  logic [7:0] cmd;
  logic [15:0] secs16;
  logic [16:0] max_secs;
  logic [16:0] secs;

  // Stall only a final item while the output register is still held
  assign pop_ready = !pop_valid || !pop_op.last || !res_valid || result.ready;
  assign pop       = pop_valid && pop_ready;

  // Mark which store entries this operation writes
  always_comb begin
    for (int d = 0; d < NumDev; d++) begin
      for (int r = 0; r < NumReg; r++) begin
        hit[d][r] = pop_op.dev_wr[d] && pop_op.reg_hit && (pop_op.reg_sel == reg_sel_t'(r));
      end
    end
  end

  // Form the selected device's registers as they stand after this write
  always_comb begin
    for (int r = 0; r < NumReg; r++) begin
      if (pop_op.dev) begin
        c_view[r] = hit[1][r] ? pop_op.value : cur[1][r];
        h_view[r] = (hit[1][r] && cur[1][r] != 8'h00) ? cur[1][r] : high[1][r];
      end else begin
        c_view[r] = hit[0][r] ? pop_op.value : cur[0][r];
        h_view[r] = (hit[0][r] && cur[0][r] != 8'h00) ? cur[0][r] : high[0][r];
      end
    end
  end

  // Build the result item
  always_comb begin
    cmd      = c_view[REG_CMD];
    secs16   = {h_view[REG_COUNT], c_view[REG_COUNT]};
    max_secs = MAX_SECS_EXT;
    res_next = '0;
    res_next.dma_direction = DIR_CALLER;
    case (cmd)
      CMD_READ_DMA_EXT: res_next.dma_direction = DIR_READ;
      CMD_READ_DMA: begin
        res_next.dma_direction = DIR_READ;
        max_secs = MAX_SECS_STD;
      end
      CMD_WRITE_DMA_EXT: res_next.dma_direction = DIR_WRITE;
      CMD_WRITE_DMA: begin
        res_next.dma_direction = DIR_WRITE;
        max_secs = MAX_SECS_STD;
      end
      default: res_next.dma_direction = DIR_CALLER;
    endcase
    secs = (secs16 == 16'h0000) ? max_secs : {1'b0, secs16};

    if (cmd == CMD_IDENTIFY_PKT && c_view[REG_FEAT] == FEAT_IDENTIFY) begin
      res_next.route_class = ROUTE_IDENTIFY;
    end else if (is_lba48(cmd)) begin
      res_next.route_class = ROUTE_LBA48;
    end else begin
      res_next.route_class = ROUTE_PLAIN;
    end

    res_next.device_index     = pop_op.dev;
    res_next.command_code     = cmd;
    res_next.taskfile_low     = {c_view[REG_FEAT], c_view[REG_COUNT], c_view[REG_SECT],
                                 c_view[REG_LCYL], c_view[REG_HCYL], c_view[REG_SEL]};
    res_next.taskfile_high    = {h_view[REG_FEAT], h_view[REG_COUNT], h_view[REG_SECT],
                                 h_view[REG_LCYL], h_view[REG_HCYL]};
    res_next.transfer_sectors = secs;
    res_next.transfer_bytes   = {secs, 9'b0};

    // Bad final tag: report the error with every other field zero
    if (!pop_op.tag_ok) begin
      res_next        = '0;
      res_next.status = 1'b1;
    end
  end

  // Update shadow stores; clear all of them after a final item
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int d = 0; d < NumDev; d++) begin
        for (int r = 0; r < NumReg; r++) begin
          cur[d][r]  <= '0;
          high[d][r] <= '0;
        end
      end
    end else if (pop) begin
      for (int d = 0; d < NumDev; d++) begin
        for (int r = 0; r < NumReg; r++) begin
          if (pop_op.last) begin
            cur[d][r]  <= '0;
            high[d][r] <= '0;
          end else if (hit[d][r]) begin
            if (cur[d][r] != 8'h00) begin
              high[d][r] <= cur[d][r];
            end
            cur[d][r] <= pop_op.value;
          end
        end
      end
    end
  end

  // Hold the result item until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (pop && pop_op.last) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && pop_op.last) begin
      res <= res_next;
    end
  end

  assign result.valid            = res_valid;
  assign result.status           = res.status;
  assign result.device_index     = res.device_index;
  assign result.command_code     = res.command_code;
  assign result.taskfile_low     = res.taskfile_low;
  assign result.taskfile_high    = res.taskfile_high;
  assign result.route_class      = res.route_class;
  assign result.dma_direction    = res.dma_direction;
  assign result.transfer_sectors = res.transfer_sectors;
  assign result.transfer_bytes   = res.transfer_bytes;

endmodule

// ===== rtl/ata_taskfile_lba48_capture_top.sv =====
// Top level of the ATA taskfile LBA48 capture block.
//
//   channel  role    carries
//   -------  ------  -----------------------------------------------------
//   entry    sink    entry_tag, entry_value, last_entry (one write item)
//   result   source  status, device, command, taskfile bytes, route, direction, size
//
// One item per cycle is accepted while the queue has room; decode happens at the
// front, the write and the result build happen in the back after the queue.
// A final item appears at the result port in the cycle after it leaves the queue.
// Reset (rst, synchronous) empties the queue and clears every shadow register.
// A held result stalls only final items; ordinary writes keep flowing.
module ata_taskfile_lba48_capture_top #(
  parameter int QUEUE_DEPTH = ataf_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  ataf_entry_if.sink    entry,
  ataf_result_if.source result
);
  import ataf_pkg::*;

  logic push_valid;
  logic push_ready;
  op_t  push_op;
  logic pop_valid;
  logic pop_ready;
  op_t  pop_op;

  ataf_front u_front (
    .entry      (entry),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op)
  );

  ataf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_op     (pop_op)
  );

  ataf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_op    (pop_op),
    .result    (result)
  );

endmodule

// ===== rtl/ataf_checker.sv =====
// Port-level checks on the result channel, bound to the top level.
module ataf_checker (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic        status,
  input logic        device_index,
  input logic [7:0]  command_code,
  input logic [47:0] taskfile_low,
  input logic [39:0] taskfile_high,
  input logic [1:0]  route_class,
  input logic [1:0]  dma_direction,
  input logic [16:0] transfer_sectors,
  input logic [25:0] transfer_bytes
);
  import ataf_pkg::*;

  // A stalled result item stays offered
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result item dropped while stalled");

  // Error results carry nothing but the status bit
  assert property (@(posedge clk) disable iff (rst)
    res_valid && status |-> !device_index && command_code == 8'h00 &&
      taskfile_low == 48'h0 && taskfile_high == 40'h0 && route_class == 2'b00 &&
      dma_direction == 2'b00 && transfer_sectors == 17'h0 && transfer_bytes == 26'h0)
    else $error("error result carries nonzero fields");

  // Good results: nonzero size, bytes follow sectors, known route and direction
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !status |-> transfer_sectors != 17'h0 &&
      transfer_bytes == {transfer_sectors, 9'b0})
    else $error("transfer size inconsistent");

  assert property (@(posedge clk) disable iff (rst)
    res_valid && !status |->
      (route_class == ROUTE_IDENTIFY || route_class == ROUTE_LBA48 ||
       route_class == ROUTE_PLAIN) &&
      (dma_direction == DIR_READ || dma_direction == DIR_WRITE ||
       dma_direction == DIR_CALLER))
    else $error("route or direction code out of range");

  // No result is offered straight after reset
  assert property (@(posedge clk) $past(rst) |-> !res_valid)
    else $error("result offered after reset");

endmodule

bind ata_taskfile_lba48_capture_top ataf_checker u_ataf_checker (
  .clk              (clk),
  .rst              (rst),
  .res_valid        (result.valid),
  .res_ready        (result.ready),
  .status           (result.status),
  .device_index     (result.device_index),
  .command_code     (result.command_code),
  .taskfile_low     (result.taskfile_low),
  .taskfile_high    (result.taskfile_high),
  .route_class      (result.route_class),
  .dma_direction    (result.dma_direction),
  .transfer_sectors (result.transfer_sectors),
  .transfer_bytes   (result.transfer_bytes)
);

// ===== tb/tb_ata_taskfile_lba48_capture_top.sv =====
// Self-checking testbench for the ATA taskfile LBA48 capture block.
module tb_ata_taskfile_lba48_capture_top;
  import ataf_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DEV_STORES = NumDev * NumReg;
  localparam logic [3:0] GROUP_BOTH = 4'h0;

  // Register codes in store order: feature first, command last
  localparam logic [7:0] REG_CODES [NumReg] = '{
    CODE_FEAT, CODE_COUNT, CODE_SECT, CODE_LCYL, CODE_HCYL, CODE_SEL, CODE_CMD
  };
  localparam logic [7:0] LBA48_CMDS [15] = '{
    8'h24, 8'h25, 8'h26, 8'h27, 8'h29, 8'h2f, 8'h34, 8'h35,
    8'h36, 8'h37, 8'h39, 8'h3f, 8'h42, 8'hea, 8'hef
  };
  localparam logic [7:0] DMA_CMDS [4] = '{
    CMD_READ_DMA_EXT, CMD_READ_DMA, CMD_WRITE_DMA_EXT, CMD_WRITE_DMA
  };

  logic clk;
  logic rst;

  ataf_entry_if  entry_ch ();
  ataf_result_if result_ch ();

  ata_taskfile_lba48_capture_top dut (
    .clk   (clk),
    .rst   (rst),
    .entry (entry_ch),
    .result(result_ch)
  );

  // Shadow copy of the taskfile stores, indexed device * NumReg + register
  logic [7:0] shadow_cur [DEV_STORES];
  logic [7:0] shadow_hob [DEV_STORES];
  res_t       pending_captures [$];

  int mismatches;
  int items_sent;
  int snd_idle_pct;
  int rcv_stall_pct;
  int hold_left;
  int quiet_cycles;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int reg_index(input logic [7:0] code);
    int idx;
    idx = -1;
    for (int i = 0; i < NumReg; i++)
      if (REG_CODES[i] == code) idx = i;
    return idx;
  endfunction

  // Apply one accepted entry to the shadow stores; queue a capture on a last entry
  task automatic capture_entry(input logic [15:0] tag, input logic [15:0] value,
                               input logic last);
    int          reg_idx;
    int          k;
    int          base;
    logic        dev;
    logic        lba48;
    logic [7:0]  cmd;
    logic [16:0] secs;
    logic [16:0] sec_max;
    res_t        cap;
    reg_idx = reg_index(tag[7:0]);
    if (reg_idx >= 0) begin
      for (int d = 0; d < NumDev; d++) begin
        if ((d == 0 && tag[11:8] != GROUP_DEV1) || (d == 1 && tag[11:8] != GROUP_DEV0)) begin
          k = d * NumReg + reg_idx;
          if (shadow_cur[k] != 8'h00) shadow_hob[k] = shadow_cur[k];
          shadow_cur[k] = value[7:0];
        end
      end
    end
    if (!last) return;

    cap = '0;
    if (tag == TAG_CMD_DEV0 || tag == TAG_CMD_DEV1) begin
      dev = (tag == TAG_CMD_DEV1);
      base = dev ? NumReg : 0;
      cmd = shadow_cur[base + REG_CMD];
      cap.device_index = dev;
      cap.command_code = cmd;
      for (int i = REG_FEAT; i <= REG_SEL; i++)
        cap.taskfile_low = {cap.taskfile_low[39:0], shadow_cur[base + i]};
      for (int i = REG_FEAT; i <= REG_HCYL; i++)
        cap.taskfile_high = {cap.taskfile_high[31:0], shadow_hob[base + i]};

      lba48 = 1'b0;
      foreach (LBA48_CMDS[i])
        if (LBA48_CMDS[i] == cmd) lba48 = 1'b1;
      if (cmd == CMD_IDENTIFY_PKT && shadow_cur[base + REG_FEAT] == FEAT_IDENTIFY)
        cap.route_class = ROUTE_IDENTIFY;
      else if (lba48)
        cap.route_class = ROUTE_LBA48;
      else
        cap.route_class = ROUTE_PLAIN;

      sec_max = MAX_SECS_EXT;
      case (cmd)
        CMD_READ_DMA_EXT: cap.dma_direction = DIR_READ;
        CMD_READ_DMA: begin
          cap.dma_direction = DIR_READ;
          sec_max = MAX_SECS_STD;
        end
        CMD_WRITE_DMA_EXT: cap.dma_direction = DIR_WRITE;
        CMD_WRITE_DMA: begin
          cap.dma_direction = DIR_WRITE;
          sec_max = MAX_SECS_STD;
        end
        default: cap.dma_direction = DIR_CALLER;
      endcase

      secs = {1'b0, shadow_hob[base + REG_COUNT], shadow_cur[base + REG_COUNT]};
      if (secs == '0) secs = sec_max;
      cap.transfer_sectors = secs;
      cap.transfer_bytes = {secs, 9'b0};
    end else begin
      cap.status = 1'b1;
    end
    pending_captures.push_back(cap);

    // Clear every store once the command has been captured
    foreach (shadow_cur[i]) begin
      shadow_cur[i] = 8'h00;
      shadow_hob[i] = 8'h00;
    end
  endtask

  // Offer one item from a falling edge, hold it until accepted, return at a falling edge
  task automatic send_entry(input logic [15:0] tag, input logic [15:0] value,
                            input logic last);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      entry_ch.valid <= 1'b0;
      @(negedge clk);
    end
    entry_ch.valid       <= 1'b1;
    entry_ch.entry_tag   <= tag;
    entry_ch.entry_value <= value;
    entry_ch.last_entry  <= last;
    do @(posedge clk); while (!entry_ch.ready);
    capture_entry(tag, value, last);
    items_sent++;
    @(negedge clk);
  endtask

  // Drop valid and wait for every queued capture to come back
  task automatic wait_captures_drained();
    entry_ch.valid <= 1'b0;
    do @(negedge clk); while (pending_captures.size() != 0);
  endtask

  function automatic logic [15:0] make_tag(input logic [3:0] group, input logic [7:0] code);
    return {4'h0, group, code};
  endfunction

  function automatic logic [7:0] pick_command();
    case ($urandom_range(0, 5))
      0:       return CMD_IDENTIFY_PKT;
      1:       return DMA_CMDS[$urandom_range(0, 3)];
      2:       return LBA48_CMDS[$urandom_range(0, 14)];
      3:       return 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  // One command: some register writes followed by a last entry, usually well formed
  task automatic send_random_command();
    logic [15:0] tag;
    logic [15:0] value;
    logic [3:0]  group;
    int          n_writes;
    n_writes = $urandom_range(0, 8);
    repeat (n_writes) begin
      case ($urandom_range(0, 2))
        0:       group = GROUP_DEV0;
        1:       group = GROUP_DEV1;
        default: group = 4'($urandom);
      endcase
      if ($urandom_range(0, 9) < 8)
        tag = make_tag(group, REG_CODES[$urandom_range(0, NumReg - 1)]);
      else
        tag = make_tag(group, 8'($urandom));
      if ($urandom_range(0, 9) == 0) tag[15:12] = 4'($urandom);
      value = 16'($urandom);
      if (tag[7:0] == CODE_COUNT && $urandom_range(0, 2) == 0) value[7:0] = 8'h00;
      if (tag[7:0] == CODE_FEAT && $urandom_range(0, 3) == 0) value[7:0] = FEAT_IDENTIFY;
      send_entry(tag, value, 1'b0);
    end
    case ($urandom_range(0, 11))
      0:       tag = 16'($urandom);
      1:       tag = TAG_CMD_DEV0 ^ (16'h1 << $urandom_range(0, 15));
      2:       tag = TAG_CMD_DEV1 ^ (16'h1 << $urandom_range(0, 15));
      default: tag = $urandom_range(0, 1) ? TAG_CMD_DEV1 : TAG_CMD_DEV0;
    endcase
    send_entry(tag, {8'($urandom), pick_command()}, 1'b1);
  endtask

  task automatic test_directed_cases();
    snd_idle_pct = 0;
    rcv_stall_pct = 0;
    // identify intercept on device 0, zero count gives the extended maximum
    send_entry(make_tag(GROUP_DEV0, CODE_FEAT), 16'h00ec, 1'b0);
    send_entry(TAG_CMD_DEV0, 16'h008e, 1'b1);
    // short read DMA on device 1 with zero count
    send_entry(make_tag(GROUP_DEV1, CODE_COUNT), 16'h0000, 1'b0);
    send_entry(TAG_CMD_DEV1, 16'hff00 | CMD_READ_DMA, 1'b1);
    // two count writes move the first byte to the high-order store
    send_entry(make_tag(GROUP_BOTH, CODE_COUNT), 16'hff34, 1'b0);
    send_entry(make_tag(GROUP_BOTH, CODE_COUNT), 16'h0012, 1'b0);
    send_entry(make_tag(GROUP_BOTH, CODE_SECT), 16'h00ff, 1'b0);
    send_entry(make_tag(GROUP_BOTH, CODE_LCYL), 16'h0001, 1'b0);
    send_entry(make_tag(GROUP_BOTH, CODE_HCYL), 16'h0080, 1'b0);
    send_entry(make_tag(GROUP_BOTH, CODE_SEL), 16'hffe0, 1'b0);
    send_entry(TAG_CMD_DEV0, 16'h0000 | CMD_READ_DMA_EXT, 1'b1);
    // extended write with zero count reaches the largest transfer
    send_entry(make_tag(4'hf, CODE_COUNT), 16'h0000, 1'b0);
    send_entry(TAG_CMD_DEV1, 16'h0000 | CMD_WRITE_DMA_EXT, 1'b1);
    send_entry(TAG_CMD_DEV0, 16'h0000 | CMD_WRITE_DMA, 1'b1);
    // a zero byte never moves to the high-order store
    send_entry(make_tag(GROUP_DEV0, CODE_SECT), 16'h0011, 1'b0);
    send_entry(make_tag(GROUP_DEV0, CODE_SECT), 16'h0022, 1'b0);
    send_entry(make_tag(GROUP_DEV0, CODE_SECT), 16'h0000, 1'b0);
    send_entry(make_tag(GROUP_DEV0, CODE_SECT), 16'h0033, 1'b0);
    send_entry(TAG_CMD_DEV0, 16'h00ef, 1'b1);
    // unknown code, then bad last tags, one of them a register write
    send_entry(make_tag(GROUP_DEV0, 8'h70), 16'habcd, 1'b0);
    send_entry(16'hffff, 16'hffff, 1'b1);
    send_entry(make_tag(GROUP_DEV1, CODE_FEAT), 16'h0011, 1'b0);
    send_entry(16'h1274, 16'h0025, 1'b1);
    // stores are clear again: plain command, zero taskfile, extended maximum size
    send_entry(TAG_CMD_DEV0, 16'h0000, 1'b1);
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input int n_items);
    int stop_at;
    snd_idle_pct = idle_pct;
    rcv_stall_pct = stall_pct;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 7) == 0)
        send_entry(16'($urandom), 16'($urandom), 1'b0);
      else
        send_random_command();
    end
  endtask

  // Hold the result side off while last entries keep coming, so the queue fills
  task automatic test_result_hold_off();
    snd_idle_pct = 0;
    rcv_stall_pct = 0;
    hold_left = HOLD_OFF_CYCLES;
    repeat (20) begin
      send_entry(make_tag(GROUP_BOTH, REG_CODES[$urandom_range(0, NumReg - 1)]),
                 16'($urandom), 1'b0);
      send_entry($urandom_range(0, 1) ? TAG_CMD_DEV1 : TAG_CMD_DEV0,
                 {8'($urandom), pick_command()}, 1'b1);
    end
  endtask

  // Result side: random stalls, or a counted hold-off when one is asked for
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
      end
    end
  end

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected 'h%0h got 'h%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Compare each accepted result with the oldest queued capture
  always @(posedge clk) begin
    res_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_captures.size() == 0) begin
        $display("%0t: unexpected result, expected none got status %0h command 'h%0h",
                 $time, result_ch.status, result_ch.command_code);
        mismatches++;
      end else begin
        want = pending_captures.pop_front();
        check_field("status", want.status, result_ch.status);
        check_field("device_index", want.device_index, result_ch.device_index);
        check_field("command_code", want.command_code, result_ch.command_code);
        check_field("taskfile_low", want.taskfile_low, result_ch.taskfile_low);
        check_field("taskfile_high", want.taskfile_high, result_ch.taskfile_high);
        check_field("route_class", want.route_class, result_ch.route_class);
        check_field("dma_direction", want.dma_direction, result_ch.dma_direction);
        check_field("transfer_sectors", want.transfer_sectors, result_ch.transfer_sectors);
        check_field("transfer_bytes", want.transfer_bytes, result_ch.transfer_bytes);
      end
    end
  end

  // End the run when nothing moves on either channel for too long
  always @(posedge clk) begin
    if ((entry_ch.valid && entry_ch.ready) || (result_ch.valid && result_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_ata_taskfile_lba48_capture_top NOT OK");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    entry_ch.valid = 1'b0;
    entry_ch.entry_tag = '0;
    entry_ch.entry_value = '0;
    entry_ch.last_entry = 1'b0;
    foreach (shadow_cur[i]) begin
      shadow_cur[i] = 8'h00;
      shadow_hob[i] = 8'h00;
    end
    mismatches = 0;
    items_sent = 0;
    snd_idle_pct = 0;
    rcv_stall_pct = 0;
    hold_left = 0;
    quiet_cycles = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_cases();
    wait_captures_drained();
    test_random_traffic(0, 0, 170);
    test_result_hold_off();
    wait_captures_drained();
    test_random_traffic(48, 0, 170);
    wait_captures_drained();
    test_random_traffic(0, 48, 170);
    test_random_traffic(31, 31, 170);
    wait_captures_drained();

    // Let any stray result surface before the verdict
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0)
      $display("tb_ata_taskfile_lba48_capture_top OK");
    else
      $display("tb_ata_taskfile_lba48_capture_top NOT OK");
    $finish;
  end

endmodule
